@@ src/overlay_slot_table_core_macros.svh @@
// ----------------------------------------------------------------------------
// Overlay slot table assertion macros
// Shared property wrappers for the overlay slot table RTL.
// ----------------------------------------------------------------------------
`ifndef OVERLAY_SLOT_TABLE_CORE_MACROS_SVH
`define OVERLAY_SLOT_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OSLT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define OSLT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/osltab_pkg.sv @@
// ----------------------------------------------------------------------------
// Overlay slot table package
// Types, widths and codes shared by the overlay slot table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package osltab_pkg;

   localparam int SLOTS_DEFAULT = 128;
   localparam int HANDLE_W      = 10;
   localparam int RES_W         = 16;
   localparam int POS_W         = 16;
   localparam int HOUT_W        = 7;

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_MODIFY = 2'd2,
      CMD_SHOW   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_BAD  = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // One slot entry as it sits in the slot RAM.
   typedef struct packed {
      logic                    show;
      logic [RES_W-1:0]        resource_id;
      logic signed [POS_W-1:0] x_pos;
      logic signed [POS_W-1:0] y_pos;
   } entry_type;

   // Control from the sequencer to the in-use tracker.
   typedef struct packed {
      logic                lookup;
      logic                set_en;
      logic                clr_en;
      logic [HANDLE_W-1:0] look_idx;
      logic [HANDLE_W-1:0] wr_idx;
   } used_ctl_type;

   // Registered lookup results from the in-use tracker.
   typedef struct packed {
      logic                full;
      logic                used_hit;
      logic [HANDLE_W-1:0] free_idx;
   } used_stat_type;

endpackage

`default_nettype wire

@@ src/osltab_req_if.sv @@
// ----------------------------------------------------------------------------
// Overlay slot table command channel
// Valid/ready channel that carries one command beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface osltab_req_if;
   import osltab_pkg::*;

   logic                    valid;
   logic                    ready;
   cmd_type                 cmd;
   logic [HANDLE_W-1:0]     handle;
   logic [RES_W-1:0]        resource_id;
   logic signed [POS_W-1:0] x_pos;
   logic signed [POS_W-1:0] y_pos;
   logic                    show;

   modport source (output valid, cmd, handle, resource_id, x_pos, y_pos, show,
                   input ready);
   modport sink   (input valid, cmd, handle, resource_id, x_pos, y_pos, show,
                   output ready);
endinterface

`default_nettype wire

@@ src/osltab_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Overlay slot table response channel
// Valid/ready channel that carries one response beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface osltab_rsp_if;
   import osltab_pkg::*;

   logic              valid;
   logic              ready;
   status_type        status;
   logic [HOUT_W-1:0] handle_out;

   modport source (output valid, status, handle_out, input ready);
   modport sink   (input valid, status, handle_out, output ready);
endinterface

`default_nettype wire

@@ src/overlay_slot_table_core.sv @@
// ----------------------------------------------------------------------------
// Overlay slot table core
// Fixed table of overlay picture slots driven by allocate, free, modify and
// display commands, one response beat per command beat.
// ----------------------------------------------------------------------------
// Flow: IDLE takes a command beat and launches the RAM read and the in-use
//    lookup; EXEC, once the response register can take it, writes back.
// Throughput: a new command waits until EXEC has done the read-modify-write of
//    the slot RAM through its single registered read port.
// Reset: the in-use bits clear at once; no clearing pass, commands are taken
//    as soon as reset is released. Slot contents are undefined until written.
`default_nettype none

`include "overlay_slot_table_core_macros.svh"

module overlay_slot_table_core #(
   parameter int SLOTS = osltab_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   osltab_req_if.sink  req_bus,
   osltab_rsp_if.source rsp_bus
);
   import osltab_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   // Range limit for the handle check, one bit wider than the handle so that
   // a table of the full handle range still compares correctly.
   localparam logic [HANDLE_W:0] SLOT_LIM = (HANDLE_W + 1)'(SLOTS);

   // Sequencer state. IDLE takes a command beat and launches the RAM read and
   // the in-use lookup; EXEC sees both results, writes back and loads the
   // response register.
   state_type state_ff;
   state_type state_in;

   // Latched command beat.
   cmd_type                 cmd_ff;
   logic [HANDLE_W-1:0]     handle_ff;
   logic [RES_W-1:0]        rid_ff;
   logic signed [POS_W-1:0] xpos_ff;
   logic signed [POS_W-1:0] ypos_ff;
   logic                    show_ff;

   // Response register; it lets the next command in while a response waits.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   status_type        status_ff;
   status_type        status_in;
   logic [HOUT_W-1:0] hout_ff;
   logic [HOUT_W-1:0] hout_in;

   logic          accept;
   logic          exec_go;
   logic          in_range;
   entry_type     ram_rdata;
   entry_type     ram_wdata;
   logic          ram_we;
   logic [IDX_W-1:0] ram_waddr;
   used_ctl_type  used_ctl;
   used_stat_type used_stat;

   assign accept  = req_bus.valid && req_bus.ready;
   // EXEC completes only when the response register is free or being drained.
   assign exec_go = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_bus.ready);
   assign in_range = {1'b0, handle_ff} < SLOT_LIM;

   assign req_bus.ready = (state_ff == ST_IDLE);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Command decode and write-back. The show bit of the entry is masked with
   // the in-use bit so that a slot never allocated reads as not shown.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      status_in    = status_ff;
      hout_in      = hout_ff;
      ram_we       = 1'b0;
      ram_waddr    = handle_ff[IDX_W-1:0];
      ram_wdata    = ram_rdata;
      ram_wdata.show = ram_rdata.show & used_stat.used_hit;

      used_ctl.lookup   = accept;
      used_ctl.look_idx = req_bus.handle;
      used_ctl.set_en   = 1'b0;
      used_ctl.clr_en   = 1'b0;
      used_ctl.wr_idx   = handle_ff;

      if (exec_go) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_OK;
         hout_in      = '0;
         unique case (cmd_ff)
            CMD_ALLOC: begin
               if (used_stat.full) begin
                  status_in = STATUS_FULL;
               end else begin
                  hout_in               = HOUT_W'(used_stat.free_idx);
                  used_ctl.set_en       = 1'b1;
                  used_ctl.wr_idx       = used_stat.free_idx;
                  ram_we                = 1'b1;
                  ram_waddr             = used_stat.free_idx[IDX_W-1:0];
                  ram_wdata.show        = 1'b0;
                  ram_wdata.resource_id = rid_ff;
                  ram_wdata.x_pos       = xpos_ff;
                  ram_wdata.y_pos       = ypos_ff;
               end
            end
            CMD_FREE: begin
               if (!in_range) begin
                  status_in = STATUS_BAD;
               end else begin
                  used_ctl.clr_en = 1'b1;
               end
            end
            CMD_MODIFY: begin
               if (!in_range || !used_stat.used_hit) begin
                  status_in = STATUS_BAD;
               end else begin
                  ram_we                = 1'b1;
                  ram_wdata.resource_id = rid_ff;
                  ram_wdata.x_pos       = xpos_ff;
                  ram_wdata.y_pos       = ypos_ff;
               end
            end
            CMD_SHOW: begin
               if (!in_range || !used_stat.used_hit) begin
                  status_in = STATUS_BAD;
               end else begin
                  ram_we         = 1'b1;
                  ram_wdata.show = show_ff;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      hout_ff   <= hout_in;
      if (accept) begin
         cmd_ff    <= req_bus.cmd;
         handle_ff <= req_bus.handle;
         rid_ff    <= req_bus.resource_id;
         xpos_ff   <= req_bus.x_pos;
         ypos_ff   <= req_bus.y_pos;
         show_ff   <= req_bus.show;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = status_ff;
   assign rsp_bus.handle_out = hout_ff;

   osltab_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (req_bus.handle[IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   osltab_used #(
      .SLOTS (SLOTS)
   ) u_used (
      .clock (clock),
      .reset (reset),
      .ctl   (used_ctl),
      .stat  (used_stat)
   );

   `OSLT_ASSERT_NXT(a_accept_to_exec, clock, reset, accept, state_ff == ST_EXEC,
      "accepted beat did not enter execution")
   `OSLT_ASSERT_IMP(a_write_in_exec, clock, reset, ram_we || used_ctl.set_en,
      exec_go, "slot state written outside execution")
   `OSLT_ASSERT_NXT(a_full_no_handle, clock, reset,
      exec_go && (cmd_ff == CMD_ALLOC) && used_stat.full,
      rsp_valid_ff && (status_ff == STATUS_FULL) && (hout_ff == '0),
      "full-table allocate gave a handle")
   `OSLT_ASSERT_IMP(a_hold_rsp, clock, reset,
      rsp_valid_ff && !rsp_bus.ready, rsp_valid_in,
      "pending response dropped")
endmodule

`default_nettype wire

@@ src/osltab_ram.sv @@
// ----------------------------------------------------------------------------
// Overlay slot table RAM
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module osltab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

`default_nettype wire

@@ src/osltab_used.sv @@
// ----------------------------------------------------------------------------
// Overlay slot table in-use tracker
// In-use bits per slot with a first-free search and a per-handle lookup.
// ----------------------------------------------------------------------------
`default_nettype none

`include "overlay_slot_table_core_macros.svh"

module osltab_used #(
   parameter int SLOTS = osltab_pkg::SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  osltab_pkg::used_ctl_type   ctl,
   output osltab_pkg::used_stat_type  stat
);
   import osltab_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);

   logic [SLOTS-1:0]    used_ff;
   logic [HANDLE_W-1:0] free_idx;
   logic                full;
   used_stat_type       stat_ff;
   used_stat_type       stat_in;

   // Lowest clear bit wins.
   always_comb begin
      free_idx = '0;
      full     = 1'b1;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = HANDLE_W'(i);
            full     = 1'b0;
         end
      end
   end

   always_comb begin
      stat_in.full     = full;
      stat_in.free_idx = free_idx;
      stat_in.used_hit = used_ff[ctl.look_idx[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (ctl.set_en) begin
         used_ff[ctl.wr_idx[IDX_W-1:0]] <= 1'b1;
      end else if (ctl.clr_en) begin
         used_ff[ctl.wr_idx[IDX_W-1:0]] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.lookup) begin
         stat_ff <= stat_in;
      end
   end

   assign stat = stat_ff;

   `OSLT_ASSERT_IMP(a_set_clr_excl, clock, reset, ctl.set_en, !ctl.clr_en,
      "in-use set and clear requested together")
   `OSLT_ASSERT_NXT(a_set_sticks, clock, reset, ctl.set_en,
      used_ff[$past(ctl.wr_idx[IDX_W-1:0])], "granted slot not marked in use")
   `OSLT_ASSERT_NXT(a_free_is_free, clock, reset, ctl.lookup && !full,
      !stat_ff.full && !used_ff[stat_ff.free_idx[IDX_W-1:0]],
      "first-free result points at a used slot")
endmodule

`default_nettype wire

@@ verif/overlay_slot_table_core_checker.sv @@
// ----------------------------------------------------------------------------
// Overlay slot table response checker
// Watches the command and response channels, predicts the answer to every
// accepted command beat and compares each response beat against it.
// ----------------------------------------------------------------------------
module overlay_slot_table_core_checker #(
   parameter int SLOTS = osltab_pkg::SLOTS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   input  logic                                      req_ready,
   input  osltab_pkg::cmd_type                       req_cmd,
   input  logic [osltab_pkg::HANDLE_W-1:0]           req_handle,
   input  logic                                      req_show,
   input  logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   input  osltab_pkg::status_type                    rsp_status,
   input  logic [osltab_pkg::HOUT_W-1:0]             rsp_handle_out,
   output int                                        mismatches,
   output int                                        answers_pending
);
   import osltab_pkg::*;

   typedef struct {
      status_type        status;
      logic [HOUT_W-1:0] handle_out;
   } slot_answer_type;

   slot_answer_type answers_due[$];

   // Only the in-use flags can influence a response; the show flags are kept as
   // well, and the id and position stores are not tracked here.
   logic in_use [SLOTS];
   logic shown  [SLOTS];

   initial begin
      mismatches      = 0;
      answers_pending = 0;
   end

   task automatic report(string msg);
      $display("[%0t] checker: %s", $time, msg);
      mismatches++;
   endtask

   // Applies one command to the tracked flags and returns its answer.
   function automatic slot_answer_type apply_command(cmd_type c, logic [HANDLE_W-1:0] h,
                                                     logic shw);
      slot_answer_type ans;
      int              idx;
      ans.status     = STATUS_OK;
      ans.handle_out = '0;
      if (c == CMD_ALLOC) begin
         ans.status = STATUS_FULL;
         for (idx = 0; idx < SLOTS; idx++) begin
            if (!in_use[idx]) begin
               in_use[idx]    = 1'b1;
               shown[idx]     = 1'b0;
               ans.status     = STATUS_OK;
               ans.handle_out = HOUT_W'(idx);
               break;
            end
         end
      end else if (int'(h) >= SLOTS) begin
         ans.status = STATUS_BAD;
      end else if (c == CMD_FREE) begin
         in_use[int'(h)] = 1'b0;
      end else if (!in_use[int'(h)]) begin
         ans.status = STATUS_BAD;
      end else if (c == CMD_SHOW) begin
         shown[int'(h)] = shw;
      end
      return ans;
   endfunction

   always @(posedge clock) begin : monitor
      slot_answer_type due;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            in_use[i] = 1'b0;
            shown[i]  = 1'b0;
         end
         answers_due.delete();
      end else begin
         // A response can never belong to a command taken at this same edge,
         // so the response side is settled first.
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               report($sformatf("response beat status %0d handle %0d with none outstanding",
                                rsp_status, rsp_handle_out));
            end else begin
               due = answers_due.pop_front();
               if (rsp_status !== due.status)
                  report($sformatf("status: expected %0d, got %0d", due.status, rsp_status));
               if (rsp_handle_out !== due.handle_out)
                  report($sformatf("handle_out: expected %0d, got %0d",
                                   due.handle_out, rsp_handle_out));
            end
         end
         if (req_valid && req_ready)
            answers_due.push_back(apply_command(req_cmd, req_handle, req_show));
      end
      answers_pending = answers_due.size();
   end

endmodule

@@ verif/overlay_slot_table_core_test.sv @@
// ----------------------------------------------------------------------------
// Overlay slot table core testbench
// Drives directed and randomized command beats into the slot table, stalls
// both channels in random bursts and leaves all prediction and comparison to
// the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module overlay_slot_table_core_test;
   import osltab_pkg::*;

   localparam int SLOTS        = SLOTS_DEFAULT;
   localparam int RANDOM_BEATS = 700;
   // The last stretch of the run goes without any stalls on either side.
   localparam int QUIET_TAIL   = 100;
   // Roughly 725 beats, stretched by idle gaps on the sender and stalls on the
   // receiver, still end with a wide margin under this limit.
   localparam int CYCLE_LIMIT  = 200000;
   // Extra cycles after the final drain, to catch any stray response beat.
   localparam int TAIL_CYCLES  = 4;

   // Command mixes used by the random phases.
   typedef enum int {
      MIX_FILL,
      MIX_GROW,
      MIX_SHRINK,
      MIX_EVEN
   } mix_type;

   logic clock;
   logic reset;
   bit   bursts_on;
   int   cycle_count;
   int   beat_count [4];
   int   mismatches;
   int   answers_pending;

   osltab_req_if req_if ();
   osltab_rsp_if rsp_if ();

   overlay_slot_table_core #(
      .SLOTS (SLOTS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   overlay_slot_table_core_checker #(
      .SLOTS (SLOTS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_cmd         (req_if.cmd),
      .req_handle      (req_if.handle),
      .req_show        (req_if.show),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_status      (rsp_if.status),
      .rsp_handle_out  (rsp_if.handle_out),
      .mismatches      (mismatches),
      .answers_pending (answers_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("overlay_slot_table_core_test: done, errors");
         $finish;
      end
   end

   // Response side. Ready changes only at the falling edge. While bursts are
   // enabled a stall starts now and then; otherwise ready stays high.
   initial begin : receiver
      int stall_left;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (bursts_on && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Presents one command beat at the falling edge and holds it until the
   // rising edge at which ready is seen high. Valid stays high on return, so
   // a following beat can go out back to back.
   task automatic send_beat(cmd_type c, logic [HANDLE_W-1:0] h, logic [RES_W-1:0] rid,
                            logic signed [POS_W-1:0] xp, logic signed [POS_W-1:0] yp,
                            logic shw);
      @(negedge clock);
      req_if.valid       <= 1'b1;
      req_if.cmd         <= c;
      req_if.handle      <= h;
      req_if.resource_id <= rid;
      req_if.x_pos       <= xp;
      req_if.y_pos       <= yp;
      req_if.show        <= shw;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      beat_count[int'(c)]++;
   endtask

   task automatic idle_gap(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
   endtask

   // Holds the sender off until every outstanding response has come back.
   // Pending is read at the falling edge, clear of the checker's update.
   task automatic drain_answers();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (answers_pending != 0) @(negedge clock);
   endtask

   // One random command. Handles lean toward the low slots, where the
   // first-free allocation puts live entries, with a share out of range so
   // that the upper handle bits toggle too.
   task automatic random_beat(mix_type mix);
      int                  roll;
      int                  pick;
      cmd_type             c;
      logic [HANDLE_W-1:0] h;
      roll = $urandom_range(0, 99);
      unique case (mix)
         MIX_FILL: c = CMD_ALLOC;
         MIX_GROW: begin
            c = (roll < 60) ? CMD_ALLOC  :
                (roll < 75) ? CMD_MODIFY :
                (roll < 90) ? CMD_SHOW   : CMD_FREE;
         end
         MIX_SHRINK: begin
            c = (roll < 55) ? CMD_FREE   :
                (roll < 70) ? CMD_ALLOC  :
                (roll < 85) ? CMD_MODIFY : CMD_SHOW;
         end
         default: c = cmd_type'(2'($urandom_range(0, 3)));
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0)
         h = HANDLE_W'($urandom_range(SLOTS, 1023));
      else if (pick < 5)
         h = HANDLE_W'($urandom_range(0, 15));
      else
         h = HANDLE_W'($urandom_range(0, SLOTS - 1));
      send_beat(c, h, RES_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                1'($urandom_range(0, 1)));
   endtask

   initial begin : stimulus
      int      random_sent;
      int      run_len;
      bit      allow_bursts;
      bit      drained_mid;
      mix_type mix;

      // Every input is known from time zero, with reset held high.
      reset              = 1'b1;
      bursts_on          = 1'b0;
      req_if.valid       = 1'b0;
      req_if.cmd         = CMD_ALLOC;
      req_if.handle      = '0;
      req_if.resource_id = '0;
      req_if.x_pos       = '0;
      req_if.y_pos       = '0;
      req_if.show        = 1'b0;
      foreach (beat_count[i]) beat_count[i] = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. The receiver stalls at random while the sender runs
      // back to back.
      bursts_on = 1'b1;
      // Commands against an empty table: freeing an unused slot is fine,
      // modify and display of an unused slot are refused.
      send_beat(CMD_FREE,   10'd0,    16'h0000, 16'sd0, 16'sd0, 1'b0);
      send_beat(CMD_MODIFY, 10'd5,    16'h1111, 16'sd1, 16'sd1, 1'b0);
      send_beat(CMD_SHOW,   10'd5,    16'h0000, 16'sd0, 16'sd0, 1'b1);
      // Handles past the end of the table are refused for free, modify and display.
      send_beat(CMD_FREE,   10'd128,  16'h0000, 16'sd0, 16'sd0, 1'b0);
      send_beat(CMD_MODIFY, 10'd1023, 16'hFFFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
      send_beat(CMD_SHOW,   10'd512,  16'h0000, 16'sd0, 16'sd0, 1'b1);
      // Allocations carrying the extreme ids and positions.
      send_beat(CMD_ALLOC,  10'd0,    16'h0000, 16'sh8000, 16'sh7FFF, 1'b0);
      send_beat(CMD_ALLOC,  10'd1023, 16'hFFFF, 16'sh7FFF, 16'sh8000, 1'b1);
      send_beat(CMD_ALLOC,  10'd0,    16'h1234, 16'sd0, 16'sd0, 1'b0);
      // Modify and display on live slots.
      send_beat(CMD_MODIFY, 10'd0,    16'hFFFF, -16'sd1, -16'sd1, 1'b0);
      send_beat(CMD_SHOW,   10'd1,    16'h0000, 16'sd0, 16'sd0, 1'b1);
      send_beat(CMD_SHOW,   10'd1,    16'h0000, 16'sd0, 16'sd0, 1'b0);
      send_beat(CMD_SHOW,   10'd2,    16'h0000, 16'sd0, 16'sd0, 1'b1);
      // A freed slot refuses modify and display, frees again without
      // complaint and is the next one handed out.
      send_beat(CMD_FREE,   10'd1,    16'h0000, 16'sd0, 16'sd0, 1'b0);
      send_beat(CMD_SHOW,   10'd1,    16'h0000, 16'sd0, 16'sd0, 1'b1);
      send_beat(CMD_MODIFY, 10'd1,    16'hABCD, 16'sd5, 16'sd5, 1'b0);
      send_beat(CMD_FREE,   10'd1,    16'h0000, 16'sd0, 16'sd0, 1'b0);
      send_beat(CMD_ALLOC,  10'd0,    16'h5A5A, 16'sd100, -16'sd100, 1'b0);
      // The last slot of the table, still unused.
      send_beat(CMD_FREE,   10'd127,  16'h0000, 16'sd0, 16'sd0, 1'b0);
      send_beat(CMD_MODIFY, 10'd127,  16'h7777, 16'sd0, 16'sd0, 1'b0);
      send_beat(CMD_SHOW,   10'd127,  16'h0000, 16'sd0, 16'sd0, 1'b1);
      // Empty the table again before the random part.
      send_beat(CMD_FREE,   10'd0,    16'h0000, 16'sd0, 16'sd0, 1'b0);
      send_beat(CMD_FREE,   10'd1,    16'h0000, 16'sd0, 16'sd0, 1'b0);
      send_beat(CMD_FREE,   10'd2,    16'h0000, 16'sd0, 16'sd0, 1'b0);

      // Let the block run dry before the random phases start.
      drain_answers();

      // Random part, in phases with different command mixes. The first phase
      // allocates past the table size so that the full answer shows up early;
      // later phases may fill it again. Each phase decides whether bursts of
      // idling are allowed, so there are calm stretches along the way.
      random_sent = 0;
      drained_mid = 1'b0;
      mix         = MIX_FILL;
      while (random_sent < RANDOM_BEATS) begin
         run_len      = (mix == MIX_FILL) ? SLOTS + 8 : $urandom_range(30, 80);
         allow_bursts = ($urandom_range(0, 3) != 0);
         for (int k = 0; k < run_len && random_sent < RANDOM_BEATS; k++) begin
            bursts_on = allow_bursts && (random_sent < RANDOM_BEATS - QUIET_TAIL);
            random_beat(mix);
            random_sent++;
            if (bursts_on && $urandom_range(0, 3) == 0)
               idle_gap($urandom_range(1, 4));
         end
         // Once, around the middle, the sender waits for a full drain.
         if (!drained_mid && random_sent >= RANDOM_BEATS / 2) begin
            drain_answers();
            drained_mid = 1'b1;
         end
         mix = mix_type'($urandom_range(0, 3));
      end

      // Wait for the last responses, then TAIL_CYCLES more for strays.
      drain_answers();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Summary: %0d command beats (allocate %0d, free %0d, modify %0d, display %0d).",
               beat_count.sum(),
               beat_count[int'(CMD_ALLOC)], beat_count[int'(CMD_FREE)],
               beat_count[int'(CMD_MODIFY)], beat_count[int'(CMD_SHOW)]);
      $display("Summary: table driven to full, bad and unused handles, bursty stalls, drains.");
      if (mismatches == 0) begin
         $display("overlay_slot_table_core_test: done, clean");
      end else begin
         $display("overlay_slot_table_core_test: done, errors");
      end
      $finish;
   end

endmodule
